[design/fca_pkg.sv]
// ============================================================================
// fca_pkg
// Shared types and constants of the file allocation table chain allocator.
// ============================================================================
package fca_pkg;

    // default table geometry
    localparam int NUM_BLOCKS_DEF      = 2048;
    localparam int RESERVED_BLOCKS_DEF = 2;

    // request field widths
    localparam int CMD_W  = 3;
    localparam int BLK_W  = 11;
    localparam int CNT_W  = 11;

    // result field widths
    localparam int STAT_W = 2;
    localparam int FREE_W = 12;

    // stream data widths (whole bytes)
    localparam int IN_W  = 32;
    localparam int OUT_W = 32;

    // request packing, lowest bit first
    localparam int IN_CMD_LSB = 0;
    localparam int IN_BLK_LSB = IN_CMD_LSB + CMD_W;
    localparam int IN_CNT_LSB = IN_BLK_LSB + BLK_W;

    // result packing, lowest bit first
    localparam int OUT_STAT_LSB = 0;
    localparam int OUT_LINK_LSB = OUT_STAT_LSB + STAT_W;
    localparam int OUT_END_LSB  = OUT_LINK_LSB + BLK_W;
    localparam int OUT_FREE_LSB = OUT_END_LSB + 1;
    localparam int OUT_USED     = OUT_FREE_LSB + FREE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_FORMAT = 3'd0,
        CMD_ALLOC  = 3'd1,
        CMD_EXTEND = 3'd2,
        CMD_FREE   = 3'd3,
        CMD_FOLLOW = 3'd4,
        CMD_COUNT  = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_SCAN_END,
        S_WALK,
        S_DONE
    } state_t;

endpackage

[design/fca_table.sv]
// ============================================================================
// fca_table
// Single write port, single read port table memory with registered read data.
// ============================================================================
module fca_table #(
    parameter int DEPTH = fca_pkg::NUM_BLOCKS_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = AW + 2
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/fat_chain_allocator.sv]
// Allocate and extend are paced by the first-fit scan, which reads one table entry per cycle;
//   free does one table read and write per link. One request is in work at a time;
//   s_tready is high only when idle.
// Reset: asynchronous, active low; afterwards a clearing pass rewrites the table with
//   s_tready low, and no result is produced for it.
// ============================================================================
// fat_chain_allocator
// File allocation table chain allocator: format, first-fit allocate, extend,
// free, follow link and free count over a linked block table with one write and one read port.
// ============================================================================
module fat_chain_allocator #(
    parameter int NUM_BLOCKS      = fca_pkg::NUM_BLOCKS_DEF,
    parameter int RESERVED_BLOCKS = fca_pkg::RESERVED_BLOCKS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // command[2:0], block_number[13:3], block_count[24:14], zero fill
    input  logic [fca_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status[1:0], link_block[12:2], link_is_end[13], free_blocks[25:14], zero fill
    output logic [fca_pkg::OUT_W-1:0] m_tdata
);

    localparam int IW   = $clog2(NUM_BLOCKS);
    localparam int EW   = IW + 2;
    localparam int FW   = $clog2(NUM_BLOCKS + 1);
    localparam int BW   = fca_pkg::BLK_W;
    localparam int CW   = fca_pkg::CNT_W;
    localparam int SW   = fca_pkg::FREE_W;
    localparam int PADW = fca_pkg::OUT_W - fca_pkg::OUT_USED;
    localparam int FREE_INIT = NUM_BLOCKS - RESERVED_BLOCKS;

    fca_pkg::state_t  state_reg, state_next;
    fca_pkg::cmd_t    cmd_reg, cmd_next;
    fca_pkg::status_t res_status_reg, res_status_next;

    logic [IW-1:0]  blk_reg, blk_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [IW:0]    ptr_reg, ptr_next;
    logic [IW-1:0]  prev_reg, prev_next;
    logic [IW-1:0]  first_reg, first_next;
    logic [IW-1:0]  cur_reg, cur_next;
    logic [CW-1:0]  got_reg, got_next;
    logic           has_prev_reg, has_prev_next;
    logic           first_step_reg, first_step_next;
    logic [FW-1:0]  free_total_reg, free_total_next;
    logic [IW-1:0]  res_link_reg, res_link_next;
    logic           res_end_reg, res_end_next;
    logic           emit_reg, emit_next;
    logic           rd_valid_reg, rd_valid_next;
    logic [IW-1:0]  rd_addr_reg, rd_addr_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [fca_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // table port
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;

    // request fields
    fca_pkg::cmd_t in_cmd;
    logic [BW-1:0] in_blk;
    logic [CW-1:0] in_cnt;
    logic [IW-1:0] in_blk_idx;

    logic          accept;
    logic          in_bad;
    logic          in_cnt_big;
    logic          in_cnt_zero;
    logic          reg_cnt_big;
    logic          reg_cnt_zero;
    logic          e_free;
    logic          e_end;
    logic [IW-1:0] e_link;
    logic          look_invalid;
    logic          link_bad;
    logic [CW-1:0] got_inc;
    logic          scan_take;
    logic          scan_last;
    logic          scan_rd;
    logic          clear_last;
    logic          out_free;

    assign in_cmd     = fca_pkg::cmd_t'(s_tdata[fca_pkg::IN_CMD_LSB +: fca_pkg::CMD_W]);
    assign in_blk     = s_tdata[fca_pkg::IN_BLK_LSB +: BW];
    assign in_cnt     = s_tdata[fca_pkg::IN_CNT_LSB +: CW];
    assign in_blk_idx = IW'(in_blk);

    assign s_tready = (state_reg == fca_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_bad       = (32'(in_blk) >= NUM_BLOCKS) || (32'(in_blk) < RESERVED_BLOCKS);
    assign in_cnt_big   = 32'(in_cnt) > 32'(free_total_reg);
    assign in_cnt_zero  = (in_cnt == '0);
    assign reg_cnt_big  = 32'(cnt_reg) > 32'(free_total_reg);
    assign reg_cnt_zero = (cnt_reg == '0);

    // entry layout: {free, end, link}
    assign e_free = rd_data[EW-1];
    assign e_end  = rd_data[EW-2];
    assign e_link = rd_data[IW-1:0];

    assign look_invalid = e_free || ((cmd_reg == fca_pkg::CMD_EXTEND) && !e_end);
    assign link_bad     = (32'(e_link) >= NUM_BLOCKS) || (32'(e_link) < RESERVED_BLOCKS);
    assign got_inc      = got_reg + CW'(1);
    assign scan_take    = rd_valid_reg && e_free;
    assign scan_last    = scan_take && (got_inc == cnt_reg);
    assign scan_rd      = 32'(ptr_reg) < NUM_BLOCKS;
    assign clear_last   = 32'(ptr_reg) == (NUM_BLOCKS - 1);
    assign out_free     = !m_tvalid_reg || m_tready;

    fca_table #(
        .DEPTH (NUM_BLOCKS),
        .AW    (IW),
        .DW    (EW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fca_pkg::S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = emit_reg ? fca_pkg::S_DONE : fca_pkg::S_IDLE;
                end
            end
            fca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        fca_pkg::CMD_FORMAT: state_next = fca_pkg::S_CLEAR;
                        fca_pkg::CMD_ALLOC:
                            state_next = (in_cnt_big || in_cnt_zero) ?
                                         fca_pkg::S_DONE : fca_pkg::S_SCAN;
                        fca_pkg::CMD_EXTEND,
                        fca_pkg::CMD_FOLLOW:
                            state_next = in_bad ? fca_pkg::S_DONE : fca_pkg::S_LOOK;
                        fca_pkg::CMD_FREE:
                            state_next = in_bad ? fca_pkg::S_DONE : fca_pkg::S_WALK;
                        default:             state_next = fca_pkg::S_DONE;
                    endcase
                end
            end
            fca_pkg::S_LOOK:
            begin
                if (look_invalid || (cmd_reg == fca_pkg::CMD_FOLLOW) ||
                    reg_cnt_big || reg_cnt_zero)
                begin
                    state_next = fca_pkg::S_DONE;
                end
                else
                begin
                    state_next = fca_pkg::S_SCAN;
                end
            end
            fca_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = fca_pkg::S_SCAN_END;
                end
            end
            fca_pkg::S_SCAN_END:
            begin
                state_next = fca_pkg::S_DONE;
            end
            fca_pkg::S_WALK:
            begin
                if (e_free || e_end || link_bad)
                begin
                    state_next = fca_pkg::S_DONE;
                end
            end
            fca_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = fca_pkg::S_IDLE;
                end
            end
            default: state_next = fca_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // table access and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_next        = cmd_reg;
        blk_next        = blk_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        got_next        = got_reg;
        has_prev_next   = has_prev_reg;
        first_step_next = first_step_reg;
        free_total_next = free_total_reg;
        res_status_next = res_status_reg;
        res_link_next   = res_link_reg;
        res_end_next    = res_end_reg;
        emit_next       = emit_reg;
        rd_valid_next   = 1'b0;
        rd_addr_next    = rd_addr_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;

        unique case (state_reg)
            fca_pkg::S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IW-1:0];
                wr_data  = {32'(ptr_reg) >= RESERVED_BLOCKS,
                            32'(ptr_reg) < RESERVED_BLOCKS, {IW{1'b0}}};
                ptr_next = ptr_reg + (IW+1)'(1);
            end
            fca_pkg::S_IDLE:
            begin
                // fetch the named entry right away
                rd_en   = accept;
                rd_addr = in_blk_idx;
                if (accept)
                begin
                    cmd_next        = in_cmd;
                    blk_next        = in_blk_idx;
                    cnt_next        = in_cnt;
                    res_status_next = fca_pkg::ST_OK;
                    res_link_next   = '0;
                    res_end_next    = 1'b0;
                    emit_next       = 1'b0;
                    unique case (in_cmd)
                        fca_pkg::CMD_FORMAT:
                        begin
                            ptr_next        = '0;
                            emit_next       = 1'b1;
                            free_total_next = FW'(FREE_INIT);
                        end
                        fca_pkg::CMD_ALLOC:
                        begin
                            if (in_cnt_big)
                            begin
                                res_status_next = fca_pkg::ST_NO_SPACE;
                            end
                            ptr_next      = (IW+1)'(RESERVED_BLOCKS);
                            got_next      = '0;
                            has_prev_next = 1'b0;
                        end
                        fca_pkg::CMD_EXTEND,
                        fca_pkg::CMD_FOLLOW:
                        begin
                            if (in_bad)
                            begin
                                res_status_next = fca_pkg::ST_INVALID;
                            end
                        end
                        fca_pkg::CMD_FREE:
                        begin
                            if (in_bad)
                            begin
                                res_status_next = fca_pkg::ST_INVALID;
                            end
                            cur_next        = in_blk_idx;
                            first_step_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fca_pkg::S_LOOK:
            begin
                priority if (look_invalid)
                begin
                    res_status_next = fca_pkg::ST_INVALID;
                end
                else if (cmd_reg == fca_pkg::CMD_FOLLOW)
                begin
                    if (e_end)
                    begin
                        res_end_next = 1'b1;
                    end
                    else
                    begin
                        res_link_next = e_link;
                    end
                end
                else if (reg_cnt_big)
                begin
                    res_status_next = fca_pkg::ST_NO_SPACE;
                end
                else if (reg_cnt_zero)
                begin
                    res_link_next = blk_reg;
                end
                else
                begin
                    ptr_next      = (IW+1)'(RESERVED_BLOCKS);
                    got_next      = '0;
                    has_prev_next = 1'b1;
                    prev_next     = blk_reg;
                end
            end
            fca_pkg::S_SCAN:
            begin
                // one read per cycle, data checked in the following cycle
                rd_en         = scan_rd;
                rd_addr       = ptr_reg[IW-1:0];
                rd_valid_next = scan_rd;
                rd_addr_next  = ptr_reg[IW-1:0];
                if (scan_rd)
                begin
                    ptr_next = ptr_reg + (IW+1)'(1);
                end
                if (scan_take)
                begin
                    // link the previous block to this one
                    wr_en   = has_prev_reg;
                    wr_addr = prev_reg;
                    wr_data = {1'b0, 1'b0, rd_addr_reg};
                    if (got_reg == '0)
                    begin
                        first_next = rd_addr_reg;
                    end
                    prev_next       = rd_addr_reg;
                    has_prev_next   = 1'b1;
                    got_next        = got_inc;
                    free_total_next = free_total_reg - FW'(1);
                end
            end
            fca_pkg::S_SCAN_END:
            begin
                // close the chain
                wr_en         = 1'b1;
                wr_addr       = prev_reg;
                wr_data       = {1'b0, 1'b1, {IW{1'b0}}};
                res_link_next = (cmd_reg == fca_pkg::CMD_ALLOC) ? first_reg : prev_reg;
            end
            fca_pkg::S_WALK:
            begin
                if (e_free)
                begin
                    if (first_step_reg)
                    begin
                        res_status_next = fca_pkg::ST_INVALID;
                    end
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = cur_reg;
                    wr_data         = {1'b1, 1'b0, {IW{1'b0}}};
                    free_total_next = free_total_reg + FW'(1);
                    first_step_next = 1'b0;
                    if (!e_end && !link_bad)
                    begin
                        // advance to the next link
                        rd_en    = 1'b1;
                        rd_addr  = e_link;
                        cur_next = e_link;
                    end
                end
            end
            fca_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PADW{1'b0}}, SW'(free_total_reg), res_end_reg,
                                     BW'(res_link_reg), res_status_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fca_pkg::S_CLEAR;
            ptr_reg        <= '0;
            emit_reg       <= 1'b0;
            free_total_reg <= FW'(FREE_INIT);
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            emit_reg       <= emit_next;
            free_total_reg <= free_total_next;
            rd_valid_reg   <= rd_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        blk_reg        <= blk_next;
        cnt_reg        <= cnt_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        cur_reg        <= cur_next;
        got_reg        <= got_next;
        has_prev_reg   <= has_prev_next;
        first_step_reg <= first_step_next;
        res_status_reg <= res_status_next;
        res_link_reg   <= res_link_next;
        res_end_reg    <= res_end_next;
        rd_addr_reg    <= rd_addr_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[design/fca_checker.sv]
// ============================================================================
// fca_checker
// Port-level checks of the chain allocator results, bound to the top level.
// ============================================================================
module fca_checker #(
    parameter int NUM_BLOCKS      = fca_pkg::NUM_BLOCKS_DEF,
    parameter int RESERVED_BLOCKS = fca_pkg::RESERVED_BLOCKS_DEF
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [fca_pkg::OUT_W-1:0] m_tdata
);

    logic [fca_pkg::STAT_W-1:0] status;
    logic [fca_pkg::BLK_W-1:0]  link;
    logic                       link_end;
    logic [fca_pkg::FREE_W-1:0] free_cnt;

    assign status   = m_tdata[fca_pkg::OUT_STAT_LSB +: fca_pkg::STAT_W];
    assign link     = m_tdata[fca_pkg::OUT_LINK_LSB +: fca_pkg::BLK_W];
    assign link_end = m_tdata[fca_pkg::OUT_END_LSB];
    assign free_cnt = m_tdata[fca_pkg::OUT_FREE_LSB +: fca_pkg::FREE_W];

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == fca_pkg::ST_OK) || (status == fca_pkg::ST_NO_SPACE) ||
                     (status == fca_pkg::ST_INVALID))
        else $error("undefined status code");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 32'(free_cnt) <= NUM_BLOCKS - RESERVED_BLOCKS)
        else $error("free count above table capacity");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && link_end |-> (link == '0) && (status == fca_pkg::ST_OK))
        else $error("end mark with a link or a failure");

    a_fail_no_link: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status != fca_pkg::ST_OK) |-> (link == '0) && !link_end)
        else $error("failed request returned a link");

endmodule

bind fat_chain_allocator fca_checker #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .RESERVED_BLOCKS (RESERVED_BLOCKS)
) u_fca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Streaming testbench for the chain allocator: a mirror of the link table
// predicts every result, and each returned result is compared field by field.
// ============================================================================

localparam int NB  = fca_pkg::NUM_BLOCKS_DEF;
localparam int RSV = fca_pkg::RESERVED_BLOCKS_DEF;
localparam int BW  = fca_pkg::BLK_W;
localparam int CW  = fca_pkg::CNT_W;
localparam int FW  = fca_pkg::FREE_W;

// codes the block must ignore
localparam logic [fca_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
localparam logic [fca_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

typedef struct {
    fca_pkg::status_t   status;
    logic [BW-1:0]      link;
    logic               at_end;
    logic [FW-1:0]      free_n;
} chain_result_t;

class link_table_mirror;
    int unsigned   link_tbl [NB];
    bit            end_mark [NB];
    bit            free_mark [NB];
    int unsigned   free_cnt;
    chain_result_t pending_results [$];
    int            mismatches;

    function new();
        clear_all();
        mismatches = 0;
    endfunction

    function void clear_all();
        for (int i = 0; i < NB; i++)
        begin
            link_tbl[i]  = 0;
            end_mark[i]  = (i < RSV);
            free_mark[i] = (i >= RSV);
        end
        free_cnt = NB - RSV;
    endfunction

    function bit unusable(int unsigned b);
        return b >= NB || b < RSV || free_mark[b];
    endfunction

    // link count free blocks, lowest first, behind prev when chained
    function void claim(int unsigned count, bit chained, int unsigned prev,
                        output int unsigned first, output int unsigned last);
        int unsigned got;
        got   = 0;
        first = 0;
        for (int unsigned i = RSV; i < NB && got < count; i++)
        begin
            if (free_mark[i])
            begin
                if (got == 0)
                    first = i;
                if (chained)
                begin
                    link_tbl[prev] = i;
                    end_mark[prev] = 1'b0;
                end
                free_mark[i] = 1'b0;
                end_mark[i]  = 1'b1;
                link_tbl[i]  = 0;
                free_cnt--;
                prev    = i;
                chained = 1'b1;
                got++;
            end
        end
        last = prev;
    endfunction

    function void take_request(logic [fca_pkg::CMD_W-1:0] c, logic [BW-1:0] b,
                               logic [CW-1:0] n);
        chain_result_t r;
        int unsigned   first, last, cur, nxt;
        bit            was_end;
        r.status = fca_pkg::ST_OK;
        r.link   = '0;
        r.at_end = 1'b0;
        case (c)
            fca_pkg::CMD_FORMAT: clear_all();
            fca_pkg::CMD_ALLOC:
            begin
                if (n > free_cnt)
                    r.status = fca_pkg::ST_NO_SPACE;
                else if (n != 0)
                begin
                    claim(32'(n), 1'b0, 0, first, last);
                    r.link = BW'(first);
                end
            end
            fca_pkg::CMD_EXTEND:
            begin
                if (unusable(32'(b)) || !end_mark[b])
                    r.status = fca_pkg::ST_INVALID;
                else if (n > free_cnt)
                    r.status = fca_pkg::ST_NO_SPACE;
                else
                begin
                    r.link = b;
                    if (n != 0)
                    begin
                        claim(32'(n), 1'b1, 32'(b), first, last);
                        r.link = BW'(last);
                    end
                end
            end
            fca_pkg::CMD_FREE:
            begin
                if (unusable(32'(b)))
                    r.status = fca_pkg::ST_INVALID;
                else
                begin
                    cur = 32'(b);
                    // walk to the end mark; stop early on a free or reserved block
                    for (int steps = 0; steps < NB; steps++)
                    begin
                        if (unusable(cur))
                            break;
                        nxt     = link_tbl[cur];
                        was_end = end_mark[cur];
                        link_tbl[cur]  = 0;
                        end_mark[cur]  = 1'b0;
                        free_mark[cur] = 1'b1;
                        free_cnt++;
                        if (was_end)
                            break;
                        cur = nxt;
                    end
                end
            end
            fca_pkg::CMD_FOLLOW:
            begin
                if (unusable(32'(b)))
                    r.status = fca_pkg::ST_INVALID;
                else if (end_mark[b])
                    r.at_end = 1'b1;
                else
                    r.link = BW'(link_tbl[b]);
            end
            default: ;
        endcase
        r.free_n = FW'(free_cnt);
        pending_results = {pending_results, r};
    endfunction

    function void match_result(logic [fca_pkg::OUT_W-1:0] d);
        chain_result_t              want;
        logic [fca_pkg::STAT_W-1:0] st;
        logic [BW-1:0]              lk;
        logic                       en;
        logic [FW-1:0]              fr;
        if (pending_results.size() == 0)
        begin
            $error("result 0x%08h arrived with no request outstanding", d);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        st = d[fca_pkg::OUT_STAT_LSB +: fca_pkg::STAT_W];
        lk = d[fca_pkg::OUT_LINK_LSB +: BW];
        en = d[fca_pkg::OUT_END_LSB];
        fr = d[fca_pkg::OUT_FREE_LSB +: FW];
        if (st !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, st);
            mismatches++;
        end
        if (lk !== want.link)
        begin
            $error("link_block: expected %0d, got %0d", want.link, lk);
            mismatches++;
        end
        if (en !== want.at_end)
        begin
            $error("link_is_end: expected %0d, got %0d", want.at_end, en);
            mismatches++;
        end
        if (fr !== want.free_n)
        begin
            $error("free_blocks: expected %0d, got %0d", want.free_n, fr);
            mismatches++;
        end
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // pick an allocated block, a chain end if asked, starting at a random index
    function logic [BW-1:0] pick_block(bit want_end);
        int unsigned start, b;
        start = $urandom_range(NB - 1);
        for (int i = 0; i < NB; i++)
        begin
            b = (start + i) % NB;
            if (b >= RSV && !free_mark[b] && (!want_end || end_mark[b]))
                return BW'(b);
        end
        return BW'($urandom_range(NB - 1));
    endfunction
endclass

module tb_top;

    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RAND_PER_PHASE = 88;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [fca_pkg::IN_W-1:0]  s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [fca_pkg::OUT_W-1:0] m_tdata;

    int tx_idle_pct = 35;
    int rx_idle_pct = 80;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    link_table_mirror book = new();

    fat_chain_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // check results and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid === 1'b1 && m_tready)
                book.match_result(m_tdata);
            if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_req(input logic [fca_pkg::CMD_W-1:0] c, input logic [BW-1:0] b,
                            input logic [CW-1:0] n);
        logic [fca_pkg::IN_W-1:0] word;
        word = '0;
        word[fca_pkg::IN_CMD_LSB +: fca_pkg::CMD_W] = c;
        word[fca_pkg::IN_BLK_LSB +: BW] = b;
        word[fca_pkg::IN_CNT_LSB +: CW] = n;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        book.take_request(c, b, n);
    endtask

    task automatic random_request();
        int unsigned               pick, size_pick;
        logic [fca_pkg::CMD_W-1:0] c;
        logic [BW-1:0]             b;
        logic [CW-1:0]             n;
        pick      = $urandom_range(99);
        size_pick = $urandom_range(99);
        b         = BW'($urandom_range(NB - 1));
        // mostly short chains, now and then a long or out-of-range one
        if (size_pick < 5)
            n = '0;
        else if (size_pick < 70)
            n = CW'($urandom_range(8, 1));
        else if (size_pick < 88)
            n = CW'($urandom_range(64, 9));
        else if (size_pick < 95)
            n = CW'($urandom_range(400, 65));
        else
            n = CW'($urandom_range(2047));
        if (pick < 28)
            c = fca_pkg::CMD_ALLOC;
        else if (pick < 48)
            c = fca_pkg::CMD_EXTEND;
        else if (pick < 63)
            c = fca_pkg::CMD_FREE;
        else if (pick < 81)
            c = fca_pkg::CMD_FOLLOW;
        else if (pick < 88)
            c = fca_pkg::CMD_COUNT;
        else if (pick < 91)
            c = fca_pkg::CMD_FORMAT;
        else
            c = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        // aim most block numbers at live chains; leave the rest as noise
        if ((c == fca_pkg::CMD_EXTEND || c == fca_pkg::CMD_FREE ||
             c == fca_pkg::CMD_FOLLOW) && $urandom_range(99) >= 15)
            b = book.pick_block(c == fca_pkg::CMD_EXTEND);
        send_req(c, b, n);
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        send_req(fca_pkg::CMD_COUNT,  11'd0, 11'd0);
        send_req(fca_pkg::CMD_FOLLOW, 11'd0, 11'd0);
        send_req(fca_pkg::CMD_FOLLOW, 11'd2, 11'd0);
        send_req(fca_pkg::CMD_ALLOC,  11'd0, 11'd0);
        send_req(fca_pkg::CMD_ALLOC,  11'd0, 11'd2047);
        send_req(fca_pkg::CMD_ALLOC,  11'd0, 11'd3);
        send_req(fca_pkg::CMD_FOLLOW, 11'd2, 11'd0);
        send_req(fca_pkg::CMD_FOLLOW, 11'd4, 11'd0);
        send_req(fca_pkg::CMD_EXTEND, 11'd2, 11'd1);
        send_req(fca_pkg::CMD_EXTEND, 11'd4, 11'd0);
        send_req(fca_pkg::CMD_EXTEND, 11'd4, 11'd2);
        send_req(fca_pkg::CMD_ALLOC,  11'd0, 11'd2);
        // free from mid-chain, then from the head up to the freed gap
        send_req(fca_pkg::CMD_FREE,   11'd5, 11'd0);
        send_req(fca_pkg::CMD_FOLLOW, 11'd4, 11'd0);
        send_req(fca_pkg::CMD_FREE,   11'd2, 11'd0);
        send_req(fca_pkg::CMD_FREE,   11'd2047, 11'd0);
        send_req(fca_pkg::CMD_FREE,   11'd1, 11'd0);
        send_req(fca_pkg::CMD_EXTEND, 11'd1, 11'd1);
        send_req(CMD_UNUSED_LO, 11'd0, 11'd0);
        send_req(CMD_UNUSED_HI, 11'd2047, 11'd2047);
        // fill the table completely, then run out of space
        send_req(fca_pkg::CMD_ALLOC,  11'd0, CW'(book.free_cnt));
        send_req(fca_pkg::CMD_ALLOC,  11'd0, 11'd1);
        send_req(fca_pkg::CMD_EXTEND, 11'd2047, 11'd0);
        send_req(fca_pkg::CMD_EXTEND, 11'd8, 11'd1);
        send_req(fca_pkg::CMD_FORMAT, 11'd0, 11'd0);
        send_req(fca_pkg::CMD_COUNT,  11'd0, 11'd0);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 35;
                    rx_idle_pct = 80;
                end
                1:
                begin
                    tx_idle_pct = 80;
                    rx_idle_pct = 35;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    hold_req    = 1'b1;
                end
            endcase
            repeat (RAND_PER_PHASE) random_request();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (book.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
